// ===== design/mhpq_pkg.sv =====
// shared constants, codes and controller/datapath link types for the max-heap queue
package mhpq_pkg;

    // heap geometry
    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CHILD_W  = ADDR_W + 2;

    // field widths of the channels
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 2;

    typedef logic signed [VALUE_W-1:0] value_t;

    // operation codes
    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    // commands from the controller to the datapath
    typedef struct packed {
        logic accept_push;
        logic accept_pop;
        logic reject_full;
        logic reject_empty;
        logic load_last;
        logic rd_parent;
        logic rd_children;
        logic wr_cur;
        logic move_up;
        logic move_down;
        logic emit;
    } cmd_t;

    // datapath flags back to the controller
    typedef struct packed {
        logic full;
        logic empty;
        logic at_root;
        logic no_left;
        logic parent_less;
        logic child_greater;
    } sts_t;

endpackage

// ===== design/mhpq_req_if.sv =====
// request channel: operation kind and value
interface mhpq_req_if;
    logic             valid;
    logic             ready;
    logic             kind;
    mhpq_pkg::value_t value;

    modport source (output valid, output kind, output value, input ready);
    modport sink (input valid, input kind, input value, output ready);
endinterface

// ===== design/mhpq_rsp_if.sv =====
// response channel: popped value, new top, count and flags
interface mhpq_rsp_if;
    logic                              valid;
    logic                              ready;
    mhpq_pkg::value_t                  popped_value;
    mhpq_pkg::value_t                  top_value;
    logic [mhpq_pkg::COUNT_W-1:0]      count;
    logic                              is_empty;
    logic                              is_full;
    logic [mhpq_pkg::STATUS_W-1:0]     status;

    modport source (output valid, output popped_value, output top_value, output count,
                    output is_empty, output is_full, output status, input ready);
    modport sink (input valid, input popped_value, input top_value, input count,
                  input is_empty, input is_full, input status, output ready);
endinterface

// ===== design/mhpq_ctrl.sv =====
// sequencer for push sift-up and pop sift-down, plus the response valid flag
module mhpq_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            in_kind,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    input  mhpq_pkg::sts_t  sts,
    output mhpq_pkg::cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP_LD,
        S_UP_CHK,
        S_UP_CMP,
        S_DN_CHK,
        S_DN_CMP,
        S_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // next state and command decode
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_kind == mhpq_pkg::KIND_PUSH)
                    begin
                        if (sts.full)
                        begin
                            cmd.reject_full = 1'b1;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            cmd.accept_push = 1'b1;
                            state_next      = S_UP_CHK;
                        end
                    end
                    else if (sts.empty)
                    begin
                        cmd.reject_empty = 1'b1;
                        state_next       = S_DONE;
                    end
                    else
                    begin
                        cmd.accept_pop = 1'b1;
                        state_next     = S_POP_LD;
                    end
                end
            end
            S_POP_LD:
            begin
                cmd.load_last = 1'b1;
                state_next    = S_DN_CHK;
            end
            S_UP_CHK:
            begin
                if (sts.at_root)
                begin
                    cmd.wr_cur = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.rd_parent = 1'b1;
                    state_next    = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                if (sts.parent_less)
                begin
                    cmd.move_up = 1'b1;
                    state_next  = S_UP_CHK;
                end
                else
                begin
                    cmd.wr_cur = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_DN_CHK:
            begin
                if (sts.no_left)
                begin
                    cmd.wr_cur = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.rd_children = 1'b1;
                    state_next      = S_DN_CMP;
                end
            end
            S_DN_CMP:
            begin
                if (sts.child_greater)
                begin
                    cmd.move_down = 1'b1;
                    state_next    = S_DN_CHK;
                end
                else
                begin
                    cmd.wr_cur = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // response valid: set on emit, cleared when the transaction is taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // a result is presented right after it is emitted
    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> out_valid_reg)
        else $error("response not valid after emit");

    // a pending response is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !cmd.emit)
        else $error("emit while response stalled");

endmodule

// ===== design/mhpq_dp.sv =====
// heap memory, fill count, sift registers and response registers
module mhpq_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  mhpq_pkg::value_t                in_value,
    input  mhpq_pkg::cmd_t                  cmd,
    output mhpq_pkg::sts_t                  sts,
    output mhpq_pkg::value_t                popped_value,
    output mhpq_pkg::value_t                top_value,
    output logic [mhpq_pkg::COUNT_W-1:0]    count,
    output logic                            is_empty,
    output logic                            is_full,
    output logic [mhpq_pkg::STATUS_W-1:0]   status
);

    // heap storage
    mhpq_pkg::value_t mem [mhpq_pkg::CAPACITY];
    mhpq_pkg::value_t rdata_a_reg;
    mhpq_pkg::value_t rdata_b_reg;

    // sift state
    logic [mhpq_pkg::CNT_W-1:0]    fill_reg;
    logic [mhpq_pkg::CNT_W-1:0]    fill_next;
    logic [mhpq_pkg::ADDR_W-1:0]   pos_reg;
    logic [mhpq_pkg::ADDR_W-1:0]   pos_next;
    mhpq_pkg::value_t              cur_reg;
    mhpq_pkg::value_t              cur_next;
    mhpq_pkg::value_t              top_reg;
    mhpq_pkg::value_t              top_next;
    mhpq_pkg::value_t              popped_reg;
    mhpq_pkg::value_t              popped_next;
    logic [mhpq_pkg::STATUS_W-1:0] status_reg;
    logic [mhpq_pkg::STATUS_W-1:0] status_next;

    // response registers
    mhpq_pkg::value_t              out_popped_reg;
    mhpq_pkg::value_t              out_top_reg;
    logic [mhpq_pkg::COUNT_W-1:0]  out_count_reg;
    logic                          out_empty_reg;
    logic                          out_full_reg;
    logic [mhpq_pkg::STATUS_W-1:0] out_status_reg;

    // index arithmetic
    logic [mhpq_pkg::CHILD_W-1:0]  left_idx;
    logic [mhpq_pkg::CHILD_W-1:0]  right_idx;
    logic [mhpq_pkg::CHILD_W-1:0]  fill_ext;
    logic [mhpq_pkg::ADDR_W-1:0]   parent_idx;
    logic [mhpq_pkg::CNT_W-1:0]    last_cnt;
    logic                          pick_right;
    mhpq_pkg::value_t              big_val;
    logic [mhpq_pkg::ADDR_W-1:0]   big_idx;

    // memory port controls
    logic                          rd_en_a;
    logic                          rd_en_b;
    logic [mhpq_pkg::ADDR_W-1:0]   rd_addr_a;
    logic [mhpq_pkg::ADDR_W-1:0]   rd_addr_b;
    logic                          wr_en;
    mhpq_pkg::value_t              wr_data;

    // children, parent and last element positions
    assign left_idx   = {1'b0, pos_reg, 1'b1};
    assign right_idx  = left_idx + mhpq_pkg::CHILD_W'(1);
    assign fill_ext   = mhpq_pkg::CHILD_W'(fill_reg);
    assign parent_idx = (pos_reg - mhpq_pkg::ADDR_W'(1)) >> 1;
    assign last_cnt   = fill_reg - mhpq_pkg::CNT_W'(1);

    // larger existing child, left on a tie
    assign pick_right = (right_idx < fill_ext) && (rdata_a_reg < rdata_b_reg);
    assign big_val    = pick_right ? rdata_b_reg : rdata_a_reg;
    assign big_idx    = pick_right ? right_idx[mhpq_pkg::ADDR_W-1:0]
                                   : left_idx[mhpq_pkg::ADDR_W-1:0];

    // flags to the controller
    assign sts.full          = (fill_reg == mhpq_pkg::CNT_W'(mhpq_pkg::CAPACITY));
    assign sts.empty         = (fill_reg == '0);
    assign sts.at_root       = (pos_reg == '0);
    assign sts.no_left       = (left_idx >= fill_ext);
    assign sts.parent_less   = (rdata_a_reg < cur_reg);
    assign sts.child_greater = (cur_reg < big_val);

    // memory port selection
    assign rd_en_a   = cmd.accept_pop || cmd.rd_parent || cmd.rd_children;
    assign rd_en_b   = cmd.rd_children;
    assign rd_addr_a = cmd.accept_pop ? last_cnt[mhpq_pkg::ADDR_W-1:0]
                     : cmd.rd_parent  ? parent_idx
                     : left_idx[mhpq_pkg::ADDR_W-1:0];
    assign rd_addr_b = right_idx[mhpq_pkg::ADDR_W-1:0];
    assign wr_en     = cmd.wr_cur || cmd.move_up || cmd.move_down;
    assign wr_data   = cmd.move_up   ? rdata_a_reg
                     : cmd.move_down ? big_val
                     : cur_reg;

    // heap memory, one write and two registered reads
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[pos_reg] <= wr_data;
        end
        if (rd_en_a)
        begin
            rdata_a_reg <= mem[rd_addr_a];
        end
        if (rd_en_b)
        begin
            rdata_b_reg <= mem[rd_addr_b];
        end
    end

    // next values of the sift registers
    always_comb
    begin
        fill_next   = fill_reg;
        pos_next    = pos_reg;
        cur_next    = cur_reg;
        top_next    = top_reg;
        popped_next = popped_reg;
        status_next = status_reg;
        if (cmd.accept_push)
        begin
            fill_next   = fill_reg + mhpq_pkg::CNT_W'(1);
            pos_next    = fill_reg[mhpq_pkg::ADDR_W-1:0];
            cur_next    = in_value;
            popped_next = '0;
            status_next = mhpq_pkg::STATUS_OK;
        end
        if (cmd.accept_pop)
        begin
            fill_next   = last_cnt;
            popped_next = top_reg;
            status_next = mhpq_pkg::STATUS_OK;
        end
        if (cmd.reject_full)
        begin
            popped_next = '0;
            status_next = mhpq_pkg::STATUS_FULL;
        end
        if (cmd.reject_empty)
        begin
            popped_next = '0;
            status_next = mhpq_pkg::STATUS_EMPTY;
        end
        if (cmd.load_last)
        begin
            cur_next = rdata_a_reg;
            pos_next = '0;
        end
        if (cmd.move_up)
        begin
            pos_next = parent_idx;
        end
        if (cmd.move_down)
        begin
            pos_next = big_idx;
        end
        // root mirror follows every write to slot zero
        if (wr_en && (pos_reg == '0))
        begin
            top_next = wr_data;
        end
    end

    // fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    // sift payload registers
    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        cur_reg    <= cur_next;
        top_reg    <= top_next;
        popped_reg <= popped_next;
        status_reg <= status_next;
    end

    // response capture
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_popped_reg <= popped_reg;
            out_top_reg    <= sts.empty ? '0 : top_reg;
            out_count_reg  <= mhpq_pkg::COUNT_W'(fill_reg);
            out_empty_reg  <= sts.empty;
            out_full_reg   <= sts.full;
            out_status_reg <= status_reg;
        end
    end

    assign popped_value = out_popped_reg;
    assign top_value    = out_top_reg;
    assign count        = out_count_reg;
    assign is_empty     = out_empty_reg;
    assign is_full      = out_full_reg;
    assign status       = out_status_reg;

    // fill count stays within capacity
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= mhpq_pkg::CNT_W'(mhpq_pkg::CAPACITY))
        else $error("fill count beyond capacity");

    // rejected operations leave the count alone
    a_reject_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.reject_full || cmd.reject_empty) |=> $stable(fill_reg))
        else $error("fill count changed on rejected operation");

    // a pop starts only on a non-empty heap and drops the count by one
    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept_pop |=> (fill_reg == $past(fill_reg) - mhpq_pkg::CNT_W'(1)))
        else $error("pop did not decrement fill count");

endmodule

// ===== design/max_heap_priority_queue_unit.sv =====
// Max-heap priority queue of signed 32-bit values, 64 entries in a single memory.
// An error result goes straight to the done state after acceptance; push and pop sift
// level by level through a check state and a compare state, paced by the
// read-then-compare of the heap memory's registered read ports.
// One item is in work at a time; the next is accepted the cycle after a result is emitted.
// Reset clears the fill count and the control state; heap memory contents are not cleared.
module max_heap_priority_queue_unit (
    input  logic        clk,
    input  logic        rst_n,
    mhpq_req_if.sink    req,
    mhpq_rsp_if.source  rsp
);

    mhpq_pkg::cmd_t cmd;
    mhpq_pkg::sts_t sts;

    // sequencer
    mhpq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_kind   (req.kind),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // storage and arithmetic
    mhpq_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_value     (req.value),
        .cmd          (cmd),
        .sts          (sts),
        .popped_value (rsp.popped_value),
        .top_value    (rsp.top_value),
        .count        (rsp.count),
        .is_empty     (rsp.is_empty),
        .is_full      (rsp.is_full),
        .status       (rsp.status)
    );

endmodule
